// ----- rtl/b64d_pkg.sv -----
// b64d_pkg: shared types, character constants and symbol lookup for the
// base64 stream decoder. No dependencies.
package b64d_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_SKIP,
    SYM_END
  } b64d_kind_t;

  typedef struct packed {
    b64d_kind_t  kind;
    logic [5:0]  value;
  } b64d_sym_t;

  // One decoded result headed for the output register.
  typedef struct packed {
    logic        valid;
    logic        ins_cr;   // emit a CR ahead of data
    logic [7:0]  data;
    logic        eom;
  } b64d_res_t;

  function automatic b64d_sym_t b64d_lookup(input logic [7:0] ch);
    b64d_sym_t s;
    s.kind  = SYM_SKIP;
    s.value = 6'd0;
    if (ch == CH_NUL) begin
      s.kind = SYM_END;
    end else if (ch inside {[8'h41:8'h5A]}) begin
      s.kind  = SYM_DATA;
      s.value = 6'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s.kind  = SYM_DATA;
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      s.kind  = SYM_DATA;
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == CH_PLUS) begin
      s.kind  = SYM_DATA;
      s.value = 6'd62;
    end else if (ch == CH_SLASH) begin
      s.kind  = SYM_DATA;
      s.value = 6'd63;
    end else if (ch == CH_PAD) begin
      s.kind = SYM_PAD;
    end
    return s;
  endfunction

endpackage

// ----- rtl/b64d_if.sv -----
// b64d_char_if / b64d_byte_if: valid/ready channels for the decoder.
// Depends on nothing.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_message;
  logic       last_in_run;

  modport source (output valid, output out_byte, output end_of_message,
                  output last_in_run, input ready);
  modport sink   (input valid, input out_byte, input end_of_message,
                  input last_in_run, output ready);
endinterface

// ----- rtl/b64d_decode.sv -----
// b64d_decode: input register, group state and symbol-to-byte decode.
// Depends on b64d_pkg and b64d_char_if.
module b64d_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                crlf_mode,
  b64d_char_if.sink           chars,
  input  logic                res_ready,
  output b64d_pkg::b64d_res_t res
);
  import b64d_pkg::*;

  logic       a_valid;
  logic [7:0] a_char;
  logic [1:0] group_position;
  logic [5:0] carry_bits;
  logic       previous_was_cr;
  logic       stopped;

  b64d_sym_t  sym;
  logic [7:0] byte_val;
  logic       emits;
  logic       take;

  assign sym = b64d_lookup(a_char);

  always_comb begin
    case (group_position)
      2'd1:    byte_val = {carry_bits, sym.value[5:4]};
      2'd2:    byte_val = {carry_bits[3:0], sym.value[5:2]};
      2'd3:    byte_val = {carry_bits[1:0], sym.value};
      default: byte_val = 8'd0;
    endcase
  end

  assign emits = !stopped && sym.kind == SYM_DATA && group_position != 2'd0;

  always_comb begin
    res.valid  = a_valid && (sym.kind == SYM_END || emits);
    res.eom    = sym.kind == SYM_END;
    res.data   = res.eom ? CH_NUL : byte_val;
    res.ins_cr = !res.eom && crlf_mode && byte_val == CH_LF && !previous_was_cr;
  end

  // A char that yields nothing never waits on the output side.
  assign take        = a_valid && (!res.valid || res_ready);
  assign chars.ready = !a_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (chars.ready) begin
      a_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      a_char <= chars.in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= 2'd0;
      carry_bits      <= 6'd0;
      previous_was_cr <= 1'b0;
      stopped         <= 1'b0;
    end else if (take) begin
      if (sym.kind == SYM_END) begin
        group_position  <= 2'd0;
        carry_bits      <= 6'd0;
        previous_was_cr <= 1'b0;
        stopped         <= 1'b0;
      end else if (!stopped && sym.kind == SYM_PAD) begin
        if (group_position >= 2'd2) begin
          stopped <= 1'b1;
        end
      end else if (!stopped && sym.kind == SYM_DATA) begin
        group_position <= group_position + 2'd1;
        case (group_position)
          2'd0:    carry_bits <= sym.value;
          2'd1:    carry_bits <= {2'b00, sym.value[3:0]};
          2'd2:    carry_bits <= {4'b0000, sym.value[1:0]};
          default: carry_bits <= 6'd0;
        endcase
        if (group_position != 2'd0) begin
          previous_was_cr <= byte_val == CH_CR;
        end
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && sym.kind == SYM_END |=> group_position == 2'd0 && !stopped && !previous_was_cr)
    else $error("end of message did not clear decoder state");

  a_group_wrap: assert property (@(posedge clk) disable iff (rst)
    take && emits && group_position == 2'd3 |=> group_position == 2'd0 && carry_bits == 6'd0)
    else $error("group did not wrap after fourth symbol");

  a_cr_only_for_lf: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ins_cr |-> res.data == CH_LF && crlf_mode)
    else $error("CR insertion requested for a byte other than LF");

endmodule

// ----- rtl/b64d_out.sv -----
// b64d_out: result register; plays out an inserted CR before its LF.
// Depends on b64d_pkg and b64d_byte_if.
module b64d_out (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::b64d_res_t res,
  output logic                res_ready,
  b64d_byte_if.source         bytes
);
  import b64d_pkg::*;

  logic       b_valid;
  logic       b_cr;
  logic [7:0] b_byte;
  logic       b_eom;

  assign res_ready = !b_valid || (bytes.ready && !b_cr);

  assign bytes.valid          = b_valid;
  assign bytes.out_byte       = b_cr ? CH_CR : b_byte;
  assign bytes.end_of_message = !b_cr && b_eom;
  assign bytes.last_in_run    = !b_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_cr    <= 1'b0;
    end else if (res_ready && res.valid) begin
      b_valid <= 1'b1;
      b_cr    <= res.ins_cr;
    end else if (b_valid && bytes.ready) begin
      // drop the pending CR first, then the byte itself
      if (b_cr) begin
        b_cr <= 1'b0;
      end else begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      b_byte <= res.data;
      b_eom  <= res.eom;
    end
  end

  a_cr_needs_valid: assert property (@(posedge clk) disable iff (rst)
    b_cr |-> b_valid)
    else $error("pending CR without a held result");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_cr && bytes.ready |=> b_valid && !b_cr && bytes.out_byte == CH_LF)
    else $error("inserted CR not followed by LF");

  a_no_load_over_cr: assert property (@(posedge clk) disable iff (rst)
    b_cr |-> !res_ready)
    else $error("new result accepted while CR still pending");

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// Base64 stream decoder: one character in, up to two bytes out.
// A character passes the input register, then the result register, to the output.
// Throughput: one character per cycle while the output takes each byte; a character
// that inserts a CR holds the single result register until its CR and LF are taken.
// Reset (rst, synchronous) clears group state, the stop flag and crlf_mode.
// Depends on b64d_pkg, b64d_if, b64d_decode and b64d_out.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  b64d_char_if.sink   char_stream,
  b64d_byte_if.source byte_stream
);
  import b64d_pkg::*;

  logic      crlf_mode;
  b64d_res_t res;
  logic      res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crlf_mode <= 1'b0;
    end else if (cfg_we) begin
      crlf_mode <= cfg_wdata;
    end
  end

  b64d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .crlf_mode (crlf_mode),
    .chars     (char_stream),
    .res_ready (res_ready),
    .res       (res)
  );

  b64d_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .bytes     (byte_stream)
  );

endmodule
